>>> src/hsa_pkg.sv
// shared widths and the request/response types of the product unit
`timescale 1ns / 1ps
`default_nettype none

package hsa_pkg;

  localparam int unsigned FIELD_W = 32;  // signed q16.16 record fields
  localparam int unsigned UFIELD_W = 31; // unsigned weight fields
  localparam int unsigned ACC_W = 48;    // internal sums, 16 fraction bits
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned HALF_W = 24;   // slice of the wide operand per multiplier pass
  localparam int unsigned PP_W = HALF_W + FIELD_W;
  localparam int unsigned PROD_W = ACC_W + FIELD_W;

  // request to the shared fixed point product unit
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] a;
    logic signed [FIELD_W-1:0] b;
  } hsa_mul_req_t;

  // response: done is high for one cycle with the floored, saturated product
  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] p;
  } hsa_mul_rsp_t;

endpackage

`default_nettype wire

>>> src/hsa_if.sv
// valid/ready channel interfaces for record words and result words
`timescale 1ns / 1ps
`default_nettype none

interface hsa_in_if;
  import hsa_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [FIELD_W-1:0]   x_value;
  logic signed [FIELD_W-1:0]   entry_weight;
  logic        [UFIELD_W-1:0]  weight;
  logic        [UFIELD_W-1:0]  inv_at_risk;
  logic signed [FIELD_W-1:0]   exposure;
  logic signed [FIELD_W-1:0]   time_gap;
  logic                        is_event;
  logic                        last_item;

  modport source (
    output valid, x_value, entry_weight, weight, inv_at_risk, exposure, time_gap,
    output is_event, last_item,
    input  ready
  );

  modport sink (
    input  valid, x_value, entry_weight, weight, inv_at_risk, exposure, time_gap,
    input  is_event, last_item,
    output ready
  );
endinterface

interface hsa_out_if;
  import hsa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] d_term;
  logic signed [FIELD_W-1:0] b_term;
  logic signed [ACC_W-1:0]   score_sum;
  logic signed [ACC_W-1:0]   cov_diag_sum;
  logic signed [ACC_W-1:0]   var_diag_sum;
  logic                      column_done;

  modport source (
    output valid, d_term, b_term, score_sum, cov_diag_sum, var_diag_sum, column_done,
    input  ready
  );

  modport sink (
    input  valid, d_term, b_term, score_sum, cov_diag_sum, var_diag_sum, column_done,
    output ready
  );
endinterface

`default_nettype wire

>>> src/hsa_qmul.sv
// multi-cycle q16 product unit: 48 x 32 signed, floored and saturated to 48 bits
`timescale 1ns / 1ps
`default_nettype none

module hsa_qmul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire hsa_pkg::hsa_mul_req_t req,
  output hsa_pkg::hsa_mul_rsp_t      rsp
);
  import hsa_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_FIN} mstate_t;

  mstate_t             state_r;
  logic [ACC_W-1:0]    ua_r;
  logic [FIELD_W-1:0]  ub_r;
  logic                neg_r;
  logic [PROD_W-1:0]   acc_r;
  logic [HALF_W-1:0]   slice;
  logic [PP_W-1:0]     pp;
  logic [PROD_W-FRAC_W-1:0] q;
  logic                ovf;
  logic [ACC_W-1:0]    ua_in;
  logic [FIELD_W-1:0]  ub_in;

  // magnitudes of the operands
  assign ua_in = req.a[ACC_W-1] ? ACC_W'(-req.a) : ACC_W'(req.a);
  assign ub_in = req.b[FIELD_W-1] ? FIELD_W'(-req.b) : FIELD_W'(req.b);

  // the one multiplier: low slice first, high slice second
  assign slice = (state_r == M_HI) ? ua_r[ACC_W-1:HALF_W] : ua_r[HALF_W-1:0];
  assign pp    = PP_W'(slice) * PP_W'(ub_r);

  assign q = acc_r[PROD_W-1:FRAC_W];

  always_comb begin
    if (neg_r) begin
      ovf = (q[PROD_W-FRAC_W-1:ACC_W] != '0) || (q[ACC_W-1] && (q[ACC_W-2:0] != '0));
    end else begin
      ovf = (q[PROD_W-FRAC_W-1:ACC_W-1] != '0);
    end
    rsp.done = (state_r == M_FIN);
    if (neg_r) begin
      rsp.p = ovf ? {1'b1, {(ACC_W-1){1'b0}}} : -$signed(q[ACC_W-1:0]);
    end else begin
      rsp.p = ovf ? {1'b0, {(ACC_W-1){1'b1}}} : $signed(q[ACC_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      unique case (state_r)
        M_IDLE: begin
          if (req.start) begin
            ua_r    <= ua_in;
            ub_r    <= ub_in;
            neg_r   <= req.a[ACC_W-1] ^ req.b[FIELD_W-1];
            state_r <= M_LO;
          end
        end
        M_LO: begin
          acc_r   <= PROD_W'(pp);
          state_r <= M_HI;
        end
        M_HI: begin
          // a negative product rounds its magnitude up, so the result floors
          acc_r   <= acc_r + {pp, {HALF_W{1'b0}}}
                     + (neg_r ? PROD_W'({FRAC_W{1'b1}}) : '0);
          state_r <= M_FIN;
        end
        M_FIN: begin
          state_r <= M_IDLE;
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/hazard_score_accumulator_unit.sv
// additive hazards score and variance accumulator for one covariate column
`timescale 1ns / 1ps
`default_nettype none

// Takes one sorted observation record per word and returns one result word per record:
// the record's D and B contributions (saturated to 32 bits) and the running score d,
// diagonal D and diagonal B sums (48 bits, 16 fraction bits, saturating). All sums clear
// after the record flagged last_item, so the next word starts a new column. How long a
// record takes from acceptance to result depends on whether it is an event and on
// compute_b; it is set by the single shared 24x32 multiplier, which works through each
// 48x32 fixed point product in a low and a high slice pass, and by the saturating adder
// steps among them. in_ch.ready is high only while no record is in work; a finished
// result sits in the output register, so the next record may be taken while it waits.
// compute_b is written through the cfg_ port at byte address 0 and read back there; it
// is sampled when a record is accepted.
module hazard_score_accumulator_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  hsa_in_if.sink          in_ch,
  hsa_out_if.source       out_ch,
  input  wire logic       cfg_psel,
  input  wire logic       cfg_penable,
  input  wire logic       cfg_pwrite,
  input  wire logic [2:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);
  import hsa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_XEW, S_CS, S_T, S_WX, S_WXE, S_EWI, S_DD, S_TG, S_INT, S_DDX, S_COV,
    S_RES, S_SC_M, S_SC_A, S_BDIFF, S_DB_M, S_WR_M, S_DB_A, S_WI_M, S_WIX_M, S_BF_A,
    S_WT_M, S_WTI_M, S_BS_A, S_DBX_M, S_VAR_A, S_OUT
  } state_t;

  localparam logic signed [ACC_W-1:0] MAX48 = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN48 = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [FIELD_W-1:0] MAX32 = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] MIN32 = {1'b1, {(FIELD_W-1){1'b0}}};

  state_t state_r, state_nxt;

  // config register
  logic compute_b_r;

  // latched record
  logic signed [FIELD_W-1:0] x_r, ew_r, ex_r, gap_r;
  logic [UFIELD_W-1:0]       w_r, iar_r;
  logic                      ev_r, last_r, cb_r;

  // column state
  logic signed [ACC_W-1:0] rcs_r, integ_r, bf_r, bs_r, score_r, cov_r, var_r;

  // per-record temporaries
  logic signed [ACC_W-1:0] tmp_r, tmp2_r, t_r, dd_r, db_r, resid_r;

  // product unit
  hsa_mul_req_t mul_req;
  hsa_mul_rsp_t mul_rsp;
  logic         mul_issued_r;
  logic         is_mul;

  // shared saturating adder
  logic signed [ACC_W-1:0] add_a, add_b, sum_sat;
  logic                    add_sub;
  logic signed [ACC_W:0]   sum_ext;

  // output register
  logic                      out_valid_r;
  logic signed [FIELD_W-1:0] d_term_r, b_term_r;
  logic signed [ACC_W-1:0]   score_sum_r, cov_diag_sum_r, var_diag_sum_r;
  logic                      column_done_r;
  logic                      out_load;
  logic signed [FIELD_W-1:0] dd_sat, db_sat;

  logic in_fire;
  logic cfg_wr;

  // operand views of the record fields
  logic signed [ACC_W-1:0]   x48, w48;
  logic signed [FIELD_W-1:0] w32, iar32;

  assign x48   = {{(ACC_W-FIELD_W){x_r[FIELD_W-1]}}, x_r};
  assign w48   = {{(ACC_W-UFIELD_W){1'b0}}, w_r};
  assign w32   = {1'b0, w_r};
  assign iar32 = {1'b0, iar_r};

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'b0, compute_b_r};
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.d_term       = d_term_r;
  assign out_ch.b_term       = b_term_r;
  assign out_ch.score_sum    = score_sum_r;
  assign out_ch.cov_diag_sum = cov_diag_sum_r;
  assign out_ch.var_diag_sum = var_diag_sum_r;
  assign out_ch.column_done  = column_done_r;

  hsa_qmul u_qmul (
    .clk (clk),
    .rst_n (rst_n),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // operand selection per step
  always_comb begin
    is_mul    = 1'b1;
    mul_req.a = tmp_r;
    mul_req.b = x_r;
    add_a     = tmp_r;
    add_b     = tmp_r;
    add_sub   = 1'b0;
    unique case (state_r)
      S_XEW:   begin mul_req.a = x48;     mul_req.b = ew_r;  end
      S_T:     begin mul_req.a = rcs_r;   mul_req.b = iar32; end
      S_WX:    begin mul_req.a = w48;     mul_req.b = x_r;   end
      S_WXE:   begin mul_req.a = tmp_r;   mul_req.b = ex_r;  end
      S_EWI:   begin mul_req.a = integ_r; mul_req.b = ew_r;  end
      S_TG:    begin mul_req.a = t_r;     mul_req.b = gap_r; end
      S_DDX:   begin mul_req.a = dd_r;    mul_req.b = x_r;   end
      S_SC_M:  begin mul_req.a = resid_r; mul_req.b = ew_r;  end
      S_DB_M:  begin mul_req.a = tmp_r;   mul_req.b = ew_r;  end
      S_WR_M:  begin mul_req.a = resid_r; mul_req.b = w32;   end
      S_WI_M:  begin mul_req.a = w48;     mul_req.b = iar32; end
      S_WIX_M: begin mul_req.a = tmp_r;   mul_req.b = x_r;   end
      S_WT_M:  begin mul_req.a = t_r;     mul_req.b = w32;   end
      S_WTI_M: begin mul_req.a = tmp_r;   mul_req.b = iar32; end
      S_DBX_M: begin mul_req.a = db_r;    mul_req.b = x_r;   end
      S_CS:    begin is_mul = 1'b0; add_a = rcs_r;   add_b = tmp_r; end
      S_DD:    begin is_mul = 1'b0; add_a = tmp_r;   add_b = tmp2_r; end
      S_INT:   begin is_mul = 1'b0; add_a = integ_r; add_b = tmp_r; end
      S_COV:   begin is_mul = 1'b0; add_a = cov_r;   add_b = tmp_r; end
      S_RES:   begin is_mul = 1'b0; add_a = x48;     add_b = t_r;  add_sub = 1'b1; end
      S_SC_A:  begin is_mul = 1'b0; add_a = score_r; add_b = tmp_r; end
      S_BDIFF: begin is_mul = 1'b0; add_a = bf_r;    add_b = bs_r; add_sub = 1'b1; end
      S_DB_A:  begin is_mul = 1'b0; add_a = db_r;    add_b = tmp_r; end
      S_BF_A:  begin is_mul = 1'b0; add_a = bf_r;    add_b = tmp_r; end
      S_BS_A:  begin is_mul = 1'b0; add_a = bs_r;    add_b = tmp_r; end
      S_VAR_A: begin is_mul = 1'b0; add_a = var_r;   add_b = tmp_r; end
      default: begin is_mul = 1'b0; end
    endcase
    mul_req.start = is_mul && !mul_issued_r;
  end

  // saturating 48-bit add or subtract
  always_comb begin
    if (add_sub) begin
      sum_ext = {add_a[ACC_W-1], add_a} - {add_b[ACC_W-1], add_b};
    end else begin
      sum_ext = {add_a[ACC_W-1], add_a} + {add_b[ACC_W-1], add_b};
    end
    if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
      sum_sat = sum_ext[ACC_W] ? MIN48 : MAX48;
    end else begin
      sum_sat = sum_ext[ACC_W-1:0];
    end
  end

  // 32-bit saturation of the record terms
  always_comb begin
    if (dd_r[ACC_W-1:FIELD_W-1] == '0 || dd_r[ACC_W-1:FIELD_W-1] == '1) begin
      dd_sat = dd_r[FIELD_W-1:0];
    end else begin
      dd_sat = dd_r[ACC_W-1] ? MIN32 : MAX32;
    end
    if (db_r[ACC_W-1:FIELD_W-1] == '0 || db_r[ACC_W-1:FIELD_W-1] == '1) begin
      db_sat = db_r[FIELD_W-1:0];
    end else begin
      db_sat = db_r[ACC_W-1] ? MIN32 : MAX32;
    end
  end

  // step sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_XEW;
      S_XEW:   if (mul_rsp.done) state_nxt = S_CS;
      S_CS:    state_nxt = S_T;
      S_T:     if (mul_rsp.done) state_nxt = S_WX;
      S_WX:    if (mul_rsp.done) state_nxt = S_WXE;
      S_WXE:   if (mul_rsp.done) state_nxt = S_EWI;
      S_EWI:   if (mul_rsp.done) state_nxt = S_DD;
      S_DD:    state_nxt = S_TG;
      S_TG:    if (mul_rsp.done) state_nxt = S_INT;
      S_INT:   state_nxt = S_DDX;
      S_DDX:   if (mul_rsp.done) state_nxt = S_COV;
      S_COV:   state_nxt = S_RES;
      S_RES: begin
        priority if (ev_r) state_nxt = S_SC_M;
        else if (cb_r)     state_nxt = S_BDIFF;
        else               state_nxt = S_OUT;
      end
      S_SC_M:  if (mul_rsp.done) state_nxt = S_SC_A;
      S_SC_A:  state_nxt = cb_r ? S_BDIFF : S_OUT;
      S_BDIFF: state_nxt = S_DB_M;
      S_DB_M:  if (mul_rsp.done) state_nxt = ev_r ? S_WR_M : S_DBX_M;
      S_WR_M:  if (mul_rsp.done) state_nxt = S_DB_A;
      S_DB_A:  state_nxt = S_WI_M;
      S_WI_M:  if (mul_rsp.done) state_nxt = S_WIX_M;
      S_WIX_M: if (mul_rsp.done) state_nxt = S_BF_A;
      S_BF_A:  state_nxt = S_WT_M;
      S_WT_M:  if (mul_rsp.done) state_nxt = S_WTI_M;
      S_WTI_M: if (mul_rsp.done) state_nxt = S_BS_A;
      S_BS_A:  state_nxt = S_DBX_M;
      S_DBX_M: if (mul_rsp.done) state_nxt = S_VAR_A;
      S_VAR_A: state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      compute_b_r  <= 1'b1;
      mul_issued_r <= 1'b0;
      out_valid_r  <= 1'b0;
      rcs_r        <= '0;
      integ_r      <= '0;
      bf_r         <= '0;
      bs_r         <= '0;
      score_r      <= '0;
      cov_r        <= '0;
      var_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        compute_b_r <= cfg_pwdata[0];
      end

      // product handshake: one start per multiply step
      if (is_mul) begin
        mul_issued_r <= !mul_rsp.done;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            x_r    <= in_ch.x_value;
            ew_r   <= in_ch.entry_weight;
            w_r    <= in_ch.weight;
            iar_r  <= in_ch.inv_at_risk;
            ex_r   <= in_ch.exposure;
            gap_r  <= in_ch.time_gap;
            ev_r   <= in_ch.is_event;
            last_r <= in_ch.last_item;
            cb_r   <= compute_b_r;
            db_r   <= '0;
          end
        end
        S_XEW, S_WX, S_WXE, S_TG, S_DDX, S_SC_M, S_WR_M, S_WI_M, S_WIX_M, S_WT_M,
        S_WTI_M, S_DBX_M: begin
          if (mul_rsp.done) tmp_r <= mul_rsp.p;
        end
        S_T:     if (mul_rsp.done) t_r <= mul_rsp.p;
        S_EWI:   if (mul_rsp.done) tmp2_r <= mul_rsp.p;
        S_DB_M:  if (mul_rsp.done) db_r <= mul_rsp.p;
        S_CS:    rcs_r <= sum_sat;
        S_DD:    dd_r <= sum_sat;
        S_INT:   integ_r <= sum_sat;
        S_COV:   cov_r <= sum_sat;
        S_RES:   resid_r <= sum_sat;
        S_SC_A:  score_r <= sum_sat;
        S_BDIFF: tmp_r <= sum_sat;
        S_DB_A:  db_r <= sum_sat;
        S_BF_A:  bf_r <= sum_sat;
        S_BS_A:  bs_r <= sum_sat;
        S_VAR_A: var_r <= sum_sat;
        S_OUT: begin
          if (out_load) begin
            d_term_r       <= dd_sat;
            b_term_r       <= db_sat;
            score_sum_r    <= score_r;
            cov_diag_sum_r <= cov_r;
            var_diag_sum_r <= var_r;
            column_done_r  <= last_r;
            // column closed: start the next one from zero
            if (last_r) begin
              rcs_r   <= '0;
              integ_r <= '0;
              bf_r    <= '0;
              bs_r    <= '0;
              score_r <= '0;
              cov_r   <= '0;
              var_r   <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // one record in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("record accepted while another is in work");

  // the product unit only answers a request that was issued
  a_mul_answered: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (mul_issued_r && is_mul))
    else $error("product returned with no request pending");

  // B contribution is zero when B terms are off
  a_b_off: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && !cb_r |-> (db_r == '0))
    else $error("nonzero b contribution with compute_b off");

  // all column sums are zero after the closing result
  a_col_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_r |=> (rcs_r == '0 && integ_r == '0 && bf_r == '0 && bs_r == '0
                            && score_r == '0 && cov_r == '0 && var_r == '0))
    else $error("column sums not cleared after last record");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// self-checking testbench for the hazard score accumulator unit
`timescale 1ns / 1ps

module tb;
  import hsa_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned DIRECTED_ROWS   = 18;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned PRESSURE_PHASE  = 2;
  localparam int unsigned HOLD_CYCLES     = 600;   // long output stall, fills the block
  localparam int unsigned MAX_GAP         = 90;    // longest sender pause, beyond one record
  localparam int unsigned DRAIN_CYCLES    = 80;    // longer than the slowest record takes
  localparam int unsigned WATCHDOG_LIMIT  = 4000;  // cycles without any handshake
  localparam int unsigned MAX_REPORTS     = 10;

  localparam logic [2:0] REG_COMPUTE_B = 3'd0;

  localparam logic signed [95:0] SAT_HI = 96'sh7FFF_FFFF_FFFF;
  localparam logic signed [95:0] SAT_LO = -96'sh8000_0000_0000;

  // one observation record as it goes into the input channel
  typedef struct packed {
    logic signed [FIELD_W-1:0]  x_value;
    logic signed [FIELD_W-1:0]  entry_weight;
    logic        [UFIELD_W-1:0] weight;
    logic        [UFIELD_W-1:0] inv_at_risk;
    logic signed [FIELD_W-1:0]  exposure;
    logic signed [FIELD_W-1:0]  time_gap;
    logic                       is_event;
    logic                       last_item;
  } record_t;

  // one result word as it leaves the output channel
  typedef struct packed {
    logic signed [FIELD_W-1:0] d_term;
    logic signed [FIELD_W-1:0] b_term;
    logic signed [ACC_W-1:0]   score_sum;
    logic signed [ACC_W-1:0]   cov_diag_sum;
    logic signed [ACC_W-1:0]   var_diag_sum;
    logic                      column_done;
  } result_t;

  // directed row: the record, and a hand-written result where it is obvious
  typedef struct packed {
    record_t rec;
    logic    typed;
    result_t res;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst_n;

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hsa_in_if  in_ch ();
  hsa_out_if out_ch ();

  hazard_score_accumulator_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // column predictor: its own copy of the seven sums and of compute_b
  // ---------------------------------------------------------------------------
  logic                    b_enabled       = 1'b1;
  logic signed [ACC_W-1:0] cov_running     = '0;
  logic signed [ACC_W-1:0] integ_term      = '0;
  logic signed [ACC_W-1:0] b_first         = '0;
  logic signed [ACC_W-1:0] b_second        = '0;
  logic signed [ACC_W-1:0] score_total     = '0;
  logic signed [ACC_W-1:0] cov_diag_total  = '0;
  logic signed [ACC_W-1:0] var_diag_total  = '0;

  result_t pending_results[$];  // predicted words, oldest first

  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned records_sent   = 0;
  int unsigned columns_sent   = 0;
  int unsigned events_sent    = 0;
  int unsigned b_off_records  = 0;
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned stall_cycles   = 0;
  logic        hold_request   = 1'b0;

  // clamp a wide value into the 48-bit accumulator range
  function automatic logic signed [ACC_W-1:0] clamp48(input logic signed [95:0] v);
    if (v > SAT_HI) return SAT_HI[ACC_W-1:0];
    if (v < SAT_LO) return SAT_LO[ACC_W-1:0];
    return v[ACC_W-1:0];
  endfunction

  // q16 product: exact product, floored by the arithmetic shift, then clamped
  function automatic logic signed [ACC_W-1:0] fx_mul(input logic signed [ACC_W-1:0] a,
                                                     input logic signed [ACC_W-1:0] b);
    logic signed [95:0] wa;
    logic signed [95:0] wb;
    wa = 96'(a);
    wb = 96'(b);
    return clamp48((wa * wb) >>> FRAC_W);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [95:0] wa;
    logic signed [95:0] wb;
    wa = 96'(a);
    wb = 96'(b);
    return clamp48(wa + wb);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [95:0] wa;
    logic signed [95:0] wb;
    wa = 96'(a);
    wb = 96'(b);
    return clamp48(wa - wb);
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return 32'h8000_0000;
    return v[FIELD_W-1:0];
  endfunction

  // advance the column by one record and return the word the block must give
  function automatic result_t column_step(input record_t r);
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] ew;
    logic signed [ACC_W-1:0] w;
    logic signed [ACC_W-1:0] iar;
    logic signed [ACC_W-1:0] ex;
    logic signed [ACC_W-1:0] gap;
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] dd;
    logic signed [ACC_W-1:0] db;
    logic signed [ACC_W-1:0] resid;
    result_t res;
    x   = ACC_W'(r.x_value);
    ew  = ACC_W'(r.entry_weight);
    w   = {17'b0, r.weight};
    iar = {17'b0, r.inv_at_risk};
    ex  = ACC_W'(r.exposure);
    gap = ACC_W'(r.time_gap);
    db  = '0;

    cov_running    = sat_add(cov_running, fx_mul(x, ew));
    t              = fx_mul(cov_running, iar);
    dd             = sat_add(fx_mul(fx_mul(w, x), ex), fx_mul(ew, integ_term));
    integ_term     = sat_add(integ_term, fx_mul(t, gap));
    cov_diag_total = sat_add(cov_diag_total, fx_mul(dd, x));
    resid          = sat_sub(x, t);
    if (r.is_event) score_total = sat_add(score_total, fx_mul(ew, resid));

    // B terms only while enabled; the sums hold their values otherwise
    if (b_enabled) begin
      db = fx_mul(ew, sat_sub(b_first, b_second));
      if (r.is_event) begin
        db       = sat_add(db, fx_mul(w, resid));
        b_first  = sat_add(b_first, fx_mul(fx_mul(w, iar), x));
        b_second = sat_add(b_second, fx_mul(fx_mul(w, t), iar));
      end
      var_diag_total = sat_add(var_diag_total, fx_mul(db, x));
    end

    res = '{clamp32(dd), clamp32(db), score_total, cov_diag_total, var_diag_total,
            r.last_item};

    // the closing word shows the final sums, then the column starts over
    if (r.last_item) begin
      cov_running    = '0;
      integ_term     = '0;
      b_first        = '0;
      b_second       = '0;
      score_total    = '0;
      cov_diag_total = '0;
      var_diag_total = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly small q16 values so that sums grow slowly, some raw bit patterns,
  // some extremes; nonneg keeps the small values non-negative for the weight fields
  function automatic logic [31:0] rand_field(input bit nonneg);
    logic [31:0] v;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) begin
      if (nonneg) v = $urandom_range(0, 32'h3_FFFF);
      else        v = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    end else if (sel < 85) begin
      v = $urandom();
    end else begin
      case ($urandom_range(6))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'h0000_0000;
        3:       v = 32'hFFFF_FFFF;
        4:       v = 32'h0000_0001;
        5:       v = 32'h0001_0000;
        default: v = 32'hFFFF_0000;
      endcase
    end
    return v;
  endfunction

  // offer one record word, wait for the handshake, then predict its result;
  // valid stays high on return so the next record follows without a bubble
  task automatic push_record(input record_t r, input bit typed, input result_t typed_res);
    result_t predicted;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    in_ch.x_value      <= r.x_value;
    in_ch.entry_weight <= r.entry_weight;
    in_ch.weight       <= r.weight;
    in_ch.inv_at_risk  <= r.inv_at_risk;
    in_ch.exposure     <= r.exposure;
    in_ch.time_gap     <= r.time_gap;
    in_ch.is_event     <= r.is_event;
    in_ch.last_item    <= r.last_item;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predicted = column_step(r);
    pending_results.push_back(typed ? typed_res : predicted);
    records_sent++;
    if (r.last_item) columns_sent++;
    if (r.is_event) events_sent++;
    if (!b_enabled) b_off_records++;
  endtask

  // read compute_b back and compare it with the model copy
  task automatic check_compute_b();
    logic [31:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= REG_COMPUTE_B;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== {31'b0, b_enabled}) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t compute_b readback %h, expected %0d", $time, readback, b_enabled);
    end
  endtask

  // write compute_b once the block has drained, then read it back;
  // the read setup follows the write access directly, psel stays high
  task automatic set_compute_b(input logic value);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_COMPUTE_B;
    cfg_pwdata  <= {31'b0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    b_enabled = value;
    check_compute_b();
  endtask

  // compare one accepted result word with the oldest prediction
  task automatic check_result();
    result_t got;
    result_t want;
    got = '{out_ch.d_term, out_ch.b_term, out_ch.score_sum, out_ch.cov_diag_sum,
            out_ch.var_diag_sum, out_ch.column_done};
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t result word with nothing pending: d %h b %h score %h cov %h var %h",
                 $time, got.d_term, got.b_term, got.score_sum, got.cov_diag_sum,
                 got.var_diag_sum);
    end else begin
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t word %0d exp/got: d %h/%h b %h/%h score %h/%h cov %h/%h ",
                    "var %h/%h done %b/%b"}, $time, results_seen,
                   want.d_term, got.d_term, want.b_term, got.b_term,
                   want.score_sum, got.score_sum, want.cov_diag_sum, got.cov_diag_sum,
                   want.var_diag_sum, got.var_diag_sum, want.column_done, got.column_done);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: check on each handshake, then pick ready for the next cycle;
  // a requested hold keeps ready low for a counted stretch
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result();
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // watchdog: any stretch without a handshake on either channel is a hang
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results pending",
               stall_cycles, pending_results.size());
      $display("[hazard_score_accumulator_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed rows, run with compute_b at its reset value
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // all zero, no event: nothing moves
    '{'{32'h0, 32'h0, 31'h0, 31'h0, 32'h0, 32'h0, 1'b0, 1'b0}, 1'b1,
      '{32'h0, 32'h0, 48'h0, 48'h0, 48'h0, 1'b0}},
    // all zero event closing the column
    '{'{32'h0, 32'h0, 31'h0, 31'h0, 32'h0, 32'h0, 1'b1, 1'b1}, 1'b1,
      '{32'h0, 32'h0, 48'h0, 48'h0, 48'h0, 1'b1}},
    // every field at its maximum: each sum saturates on its first product
    '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
        48'h8000_0000_0000, 1'b0}},
    // continue from the saturated sums
    '{'{32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0001, 32'h8000_0000,
        32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{32'h7FFF_FFFF, 32'h8000_0000, 31'h0, 31'h7FFF_FFFF, 32'h0, 32'h8000_0000,
        1'b0, 1'b1}, 1'b0, NO_RESULT},
    // minimum covariate and entry weight, zero weights: score is exactly 2^30
    '{'{32'h8000_0000, 32'h8000_0000, 31'h0, 31'h0, 32'h8000_0000, 32'h8000_0000,
        1'b1, 1'b1}, 1'b1,
      '{32'h0, 32'h0, 48'h4000_0000_0000, 48'h0, 48'h0, 1'b1}},
    // negative lsb product floors to minus one lsb
    '{'{32'hFFFF_FFFF, 32'h0000_0001, 31'h0, 31'h0, 32'h0, 32'h0, 1'b1, 1'b1}, 1'b1,
      '{32'h0, 32'h0, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h0, 1'b1}},
    // positive lsb product floors to zero
    '{'{32'h0000_0001, 32'h0000_0001, 31'h0, 31'h0, 32'h0, 32'h0, 1'b1, 1'b1}, 1'b1,
      '{32'h0, 32'h0, 48'h0, 48'h0, 48'h0, 1'b1}},
    // unit values: event, then a plain record picking up the integrated term
    '{'{32'h1_0000, 32'h1_0000, 31'h1_0000, 31'h1_0000, 32'h1_0000, 32'h1_0000,
        1'b1, 1'b0}, 1'b1,
      '{32'h1_0000, 32'h0, 48'h0, 48'h1_0000, 48'h0, 1'b0}},
    '{'{32'h1_0000, 32'h1_0000, 31'h1_0000, 31'h1_0000, 32'h1_0000, 32'h1_0000,
        1'b0, 1'b1}, 1'b1,
      '{32'h2_0000, 32'h0, 48'h0, 48'h3_0000, 48'h0, 1'b1}},
    // mixed signs and sizes, left to the predictor
    '{'{32'h0001_8000, 32'hFFFF_0000, 31'h0002_0000, 31'h0000_8000, 32'h0003_0000,
        32'h0000_4000, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{32'hFFFE_8000, 32'h0001_0000, 31'h0001_0000, 31'h0000_5555, 32'hFFFF_0000,
        32'h0001_0000, 1'b0, 1'b0}, 1'b0, NO_RESULT},
    '{'{32'h0005_0000, 32'h0001_0000, 31'h7FFF_FFFF, 31'h0000_0001, 32'h0000_0100,
        32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555, 32'hAAAA_AAAA,
        32'h5555_5555, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, 32'h5555_5555,
        32'hAAAA_AAAA, 1'b0, 1'b1}, 1'b0, NO_RESULT},
    '{'{32'h0002_0000, 32'hFFFE_0000, 31'h0001_0000, 31'h0001_0000, 32'h0001_0000,
        32'h0002_0000, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{32'hFFFF_0000, 32'h0001_0000, 31'h0000_8000, 31'h0000_4000, 32'h0002_0000,
        32'h0, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{32'h0001_0000, 32'h0001_0000, 31'h0001_0000, 31'h0, 32'h0001_0000,
        32'h0001_0000, 1'b0, 1'b1}, 1'b0, NO_RESULT}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    record_t     r;
    int unsigned col_left;
    col_left = 0;

    rst_n              <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.x_value      <= '0;
    in_ch.entry_weight <= '0;
    in_ch.weight       <= '0;
    in_ch.inv_at_risk  <= '0;
    in_ch.exposure     <= '0;
    in_ch.time_gap     <= '0;
    in_ch.is_event     <= 1'b0;
    in_ch.last_item    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset value of compute_b, then the directed table with light idling
    sender_idle_pct   = 9;
    receiver_idle_pct = 54;
    check_compute_b();
    for (int i = 0; i < DIRECTED_ROWS; i++)
      push_record(directed_rows[i].rec, directed_rows[i].typed, directed_rows[i].res);

    // random phases: compute_b alternates, so a column can span a change
    for (int phase = 0; phase < PHASES; phase++) begin
      in_ch.valid <= 1'b0;
      set_compute_b(phase[0]);
      if (phase < 3) begin
        sender_idle_pct   = 9;
        receiver_idle_pct = 54;
      end else if (phase < 6) begin
        sender_idle_pct   = 54;
        receiver_idle_pct = 9;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      // long output stall while records keep coming
      if (phase == PRESSURE_PHASE) hold_request = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mostly short columns, now and then a long one
        if (col_left == 0)
          col_left = ($urandom_range(99) < 10) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
        r.x_value      = rand_field(1'b0);
        r.entry_weight = rand_field(1'b0);
        r.weight       = UFIELD_W'(rand_field(1'b1));
        r.inv_at_risk  = UFIELD_W'(rand_field(1'b1));
        r.exposure     = rand_field(1'b0);
        r.time_gap     = rand_field(1'b0);
        r.is_event     = ($urandom_range(99) < 45);
        // a stray last flag now and then cuts a column short
        r.last_item    = (col_left == 1) || ($urandom_range(99) < 3);
        col_left       = r.last_item ? 0 : col_left - 1;
        push_record(r, 1'b0, NO_RESULT);
      end
    end

    // drain, then give a spurious word time to show up
    in_ch.valid <= 1'b0;
    receiver_idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d records in %0d closed columns, %0d events, %0d with B terms off",
             records_sent, columns_sent, events_sent, b_off_records);
    $display("run: %0d result words checked, %0d mismatches, one long output stall",
             results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[hazard_score_accumulator_unit] OK");
    else
      $display("[hazard_score_accumulator_unit] ERROR");
    $finish;
  end

endmodule

>>> hazard_score_accumulator_unit.f
src/hsa_pkg.sv
src/hsa_if.sv
src/hsa_qmul.sv
src/hazard_score_accumulator_unit.sv
dv/tb.sv
